// File: rtl/ecrp_pkg.sv
// shared constants for the embedded controller ram port
package ecrp_pkg;

  localparam int RAM_DEPTH = 256;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);

  // port access kinds
  localparam logic [1:0] REQ_STATUS = 2'd0;
  localparam logic [1:0] REQ_CMD_WR = 2'd1;
  localparam logic [1:0] REQ_DAT_WR = 2'd2;
  localparam logic [1:0] REQ_DAT_RD = 2'd3;

  // command bytes
  localparam logic [7:0] CMD_READ  = 8'h80;
  localparam logic [7:0] CMD_WRITE = 8'h81;

  // status bits
  localparam logic [7:0] ST_OBF = 8'h01;
  localparam logic [7:0] ST_IBF = 8'h02;
  localparam logic [7:0] ST_CMD = 8'h08;

  // command sequencer phases
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_RD_ADDR = 2'd1;
  localparam logic [1:0] PH_WR_ADDR = 2'd2;
  localparam logic [1:0] PH_WR_DATA = 2'd3;

endpackage

// File: rtl/ecrp_ram.sv
// generic single-port ram with registered read
module ecrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/embedded_controller_ram_port_core.sv
// top level of the embedded controller host port with its byte ram
//
// device side of an embedded controller host interface
// input channel: one beat per host port access (in_req_type, in_wdata):
//   status read, command write, data write or data read
// output channel: exactly one beat per access, out_rdata carries the status
//   byte (obf bit 0, ibf bit 1 always low, cmd bit 3) or the output buffer
//   byte; writes return zero
// command 0x80 reads the ram byte at the next data byte into the output
//   buffer, command 0x81 writes the data byte after the address byte
// result: the beat is registered and valid in the cycle after the input beat is accepted
// throughput: one access per clock while out_ready takes each result; each access does
//   at most one ram read or one ram write on the single ram port
// a ram read issued by a data write lands in the output buffer from the
//   registered ram output during the following cycle
// reset: sequencer idle, flags and buffer cleared, every ram byte reads as
//   zero through per-entry valid bits until written; no clearing pass
// receiver stall: the result register holds its beat and in_ready drops
//   until out_ready takes it, so nothing is lost
module embedded_controller_ram_port_core
  import ecrp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_req_type,
  input  logic [7:0] in_wdata,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_rdata
);

  // sequencer and host-visible state
  logic [1:0]           phase_r,   phase_nxt;
  logic [7:0]           addr_r,    addr_nxt;
  logic [7:0]           obuf_r,    obuf_nxt;
  logic                 obf_r,     obf_nxt;
  logic                 cmd_r,     cmd_nxt;
  // pending ram load into the output buffer
  logic                 load_r,    load_nxt;
  logic                 rd_ok_r,   rd_ok_nxt;
  // ram entries written since reset
  logic [RAM_DEPTH-1:0] valid_r,   valid_nxt;
  // result register
  logic                 ovalid_r,  ovalid_nxt;
  logic [7:0]           ordata_r,  ordata_nxt;

  logic              accept;
  logic              ram_we;
  logic              ram_re;
  logic [RAM_AW-1:0] ram_addr;
  logic [7:0]        ram_rdata;
  logic [7:0]        ram_val;
  logic [7:0]        obuf_cur;
  logic              wr_in_range;
  logic              rd_in_range;
  logic [RAM_AW-1:0] wr_idx;
  logic [RAM_AW-1:0] rd_idx;

  assign in_ready  = !ovalid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = ovalid_r;
  assign out_rdata = ordata_r;

  // address range checks against the ram depth
  assign wr_in_range = ({1'b0, addr_r}   < 9'(RAM_DEPTH));
  assign rd_in_range = ({1'b0, in_wdata} < 9'(RAM_DEPTH));
  assign wr_idx      = addr_r[RAM_AW-1:0];
  assign rd_idx      = in_wdata[RAM_AW-1:0];

  // ram data from the previous cycle's load, zero if never written or out of range
  assign ram_val  = rd_ok_r ? ram_rdata : 8'h00;
  // output buffer as the host sees it right now
  assign obuf_cur = load_r ? ram_val : obuf_r;

  always_comb begin
    phase_nxt  = phase_r;
    addr_nxt   = addr_r;
    obuf_nxt   = obuf_cur;
    obf_nxt    = obf_r;
    cmd_nxt    = cmd_r;
    load_nxt   = 1'b0;
    rd_ok_nxt  = rd_ok_r;
    valid_nxt  = valid_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_addr   = wr_idx;
    ovalid_nxt = ovalid_r && !out_ready;
    ordata_nxt = ordata_r;

    if (accept) begin
      ovalid_nxt = 1'b1;
      ordata_nxt = 8'h00;
      unique case (in_req_type)
        REQ_STATUS: begin
          ordata_nxt = (obf_r ? ST_OBF : 8'h00) | (cmd_r ? ST_CMD : 8'h00);
        end
        REQ_CMD_WR: begin
          // any command restarts the sequencer
          cmd_nxt = 1'b1;
          if (in_wdata == CMD_READ) begin
            phase_nxt = PH_RD_ADDR;
          end else if (in_wdata == CMD_WRITE) begin
            phase_nxt = PH_WR_ADDR;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        REQ_DAT_WR: begin
          cmd_nxt = 1'b0;
          unique case (phase_r)
            PH_RD_ADDR: begin
              // start the ram read, buffer picks it up next cycle
              addr_nxt  = in_wdata;
              ram_re    = 1'b1;
              ram_addr  = rd_idx;
              load_nxt  = 1'b1;
              rd_ok_nxt = rd_in_range && valid_r[rd_idx];
              obf_nxt   = 1'b1;
              phase_nxt = PH_IDLE;
            end
            PH_WR_ADDR: begin
              addr_nxt  = in_wdata;
              phase_nxt = PH_WR_DATA;
            end
            PH_WR_DATA: begin
              if (wr_in_range) begin
                ram_we            = 1'b1;
                valid_nxt[wr_idx] = 1'b1;
              end
              phase_nxt = PH_IDLE;
            end
            default: begin
              // data write while idle only clears cmd
            end
          endcase
        end
        REQ_DAT_RD: begin
          ordata_nxt = obuf_cur;
          obf_nxt    = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      addr_r   <= 8'h00;
      obuf_r   <= 8'h00;
      obf_r    <= 1'b0;
      cmd_r    <= 1'b0;
      load_r   <= 1'b0;
      rd_ok_r  <= 1'b0;
      valid_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      addr_r   <= addr_nxt;
      obuf_r   <= obuf_nxt;
      obf_r    <= obf_nxt;
      cmd_r    <= cmd_nxt;
      load_r   <= load_nxt;
      rd_ok_r  <= rd_ok_nxt;
      valid_r  <= valid_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // result payload needs no reset
  always_ff @(posedge clk) begin
    ordata_r <= ordata_nxt;
  end

  ecrp_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (in_wdata),
    .rdata (ram_rdata)
  );

endmodule
